// ===== hw/rtl/sca_pkg.sv =====
// Shared types and constants for the stable centroid averager.
// Used by sca_div_const and stable_centroid_averager; no dependencies.
package sca_pkg;

  localparam int unsigned SCA_WINDOW_SIZE_DEF = 5;

  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned SUM_W    = 21;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_AW   = 1;
  localparam int unsigned IN_DW    = 144;
  localparam int unsigned OUT_DW   = 104;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CFG_W-1:0] SETTLE_MS_RESET  = 16'd200;
  localparam logic [CFG_W-1:0] SPREAD_MAX_RESET = 16'd4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_START  = 1'b1;

  localparam logic [CFG_AW-1:0] CFG_SETTLE_MS  = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_SPREAD_MAX = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED  = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2,
    ST_POINT    = 2'd3
  } sca_status_t;

endpackage

// ===== hw/rtl/sca_div_const.sv =====
// Signed division of a window sum by a constant, truncated toward zero.
// Uses one reciprocal multiply; widths come from sca_pkg.
module sca_div_const
  import sca_pkg::*;
#(
  parameter int unsigned DIVISOR = SCA_WINDOW_SIZE_DEF
) (
  input  logic signed [SUM_W-1:0] num,
  output logic signed [PIX_W-1:0] quo
);

  // The shift leaves enough headroom that floor(mag * MULT >> SHIFT) is exact
  // for every magnitude below 2**SUM_W.
  localparam int unsigned SHIFT  = SUM_W + $clog2(DIVISOR) + 1;
  localparam int unsigned MULT_W = SHIFT + 1;
  localparam int unsigned PROD_W = SUM_W + MULT_W;
  localparam logic [MULT_W-1:0] MULT = MULT_W'((64'd1 << SHIFT) / DIVISOR + 1);

  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  q_mag;
  logic [SUM_W-1:0]  q_signed;

  assign neg      = num[SUM_W-1];
  assign mag      = neg ? SUM_W'(-num) : SUM_W'(num);
  assign prod     = PROD_W'(mag) * PROD_W'(MULT);
  assign q_mag    = prod[SHIFT +: SUM_W];
  assign q_signed = neg ? SUM_W'(-q_mag) : q_mag;
  assign quo      = q_signed[PIX_W-1:0];

endmodule

// ===== hw/rtl/stable_centroid_averager.sv =====
// Stable centroid averager top level; depends on sca_pkg and sca_div_const.
// A request is loaded into the input register when accepted, and its result into
// the result register once that is empty or out_tready is high. Throughput: one
// request per cycle while out_tready is high; the window update is combinational.
// Reset (rst_n low, synchronous) empties both registers, clears the window
// state and loads settle_ms = 200 and spread_max = 4.
module stable_centroid_averager
  import sca_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = SCA_WINDOW_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration write port.
  input  logic                cfg_wr_en,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]    cfg_wdata,
  // Request channel.
  input  logic                in_tvalid,
  output logic                in_tready,
  // seq_num[15:0], blob_x[31:16], blob_y[47:32], elapsed_ms[79:48],
  // motor_x_in[111:80], motor_z_in[143:112]
  input  logic [IN_DW-1:0]    in_tdata,
  // cmd[0]
  input  logic                in_tuser,
  // Result channel.
  output logic                out_tvalid,
  input  logic                out_tready,
  // count_now[4:0], unstable_seen[5], avg_x[21:6], avg_y[37:22],
  // motor_x_out[69:38], motor_z_out[101:70], zero[103:102]
  output logic [OUT_DW-1:0]   out_tdata,
  // status[1:0]
  output logic [STATUS_W-1:0] out_tuser
);

  // Configuration.
  logic [CFG_W-1:0] settle_ms_r;
  logic [CFG_W-1:0] spread_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ms_r  <= SETTLE_MS_RESET;
      spread_max_r <= SPREAD_MAX_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_SETTLE_MS:  settle_ms_r  <= cfg_wdata;
        CFG_SPREAD_MAX: spread_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  logic                     s1_valid_r;
  logic                     s1_cmd_r;
  logic [SEQ_W-1:0]         s1_seq_r;
  logic signed [PIX_W-1:0]  s1_cx_r;
  logic signed [PIX_W-1:0]  s1_cy_r;
  logic [TIME_W-1:0]        s1_elapsed_r;
  logic signed [POS_W-1:0]  s1_mx_r;
  logic signed [POS_W-1:0]  s1_mz_r;

  logic in_fire;
  logic adv;

  assign adv       = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r     <= in_tuser;
      s1_seq_r     <= in_tdata[15:0];
      s1_cx_r      <= in_tdata[31:16];
      s1_cy_r      <= in_tdata[47:32];
      s1_elapsed_r <= in_tdata[79:48];
      s1_mx_r      <= in_tdata[111:80];
      s1_mz_r      <= in_tdata[143:112];
    end
  end

  // Window state.
  logic [SEQ_W-1:0]        last_seq_r,   last_seq_nxt;
  logic [CNT_W-1:0]        count_r,      count_nxt;
  logic signed [SUM_W-1:0] sum_x_r,      sum_x_nxt;
  logic signed [SUM_W-1:0] sum_y_r,      sum_y_nxt;
  logic signed [PIX_W-1:0] min_x_r,      min_x_nxt;
  logic signed [PIX_W-1:0] max_x_r,      max_x_nxt;
  logic signed [PIX_W-1:0] min_y_r,      min_y_nxt;
  logic signed [PIX_W-1:0] max_y_r,      max_y_nxt;
  logic                    unstable_r,   unstable_nxt;
  logic                    done_r,       done_nxt;

  // Candidate values if the sample is taken.
  logic                    take;
  logic                    first;
  logic [CNT_W-1:0]        count_new;
  logic signed [SUM_W-1:0] sum_x_new;
  logic signed [SUM_W-1:0] sum_y_new;
  logic signed [PIX_W-1:0] min_x_new;
  logic signed [PIX_W-1:0] max_x_new;
  logic signed [PIX_W-1:0] min_y_new;
  logic signed [PIX_W-1:0] max_y_new;
  logic [PIX_W:0]          spread_x;
  logic [PIX_W:0]          spread_y;
  logic                    too_wide;
  logic signed [PIX_W-1:0] avg_x_q;
  logic signed [PIX_W-1:0] avg_y_q;

  assign take = (s1_cmd_r == CMD_SAMPLE) && !done_r &&
                (s1_elapsed_r >= TIME_W'(settle_ms_r)) && (s1_seq_r != last_seq_r);
  assign first     = (count_r == '0);
  assign count_new = count_r + CNT_W'(1);
  assign sum_x_new = sum_x_r + SUM_W'(s1_cx_r);
  assign sum_y_new = sum_y_r + SUM_W'(s1_cy_r);
  assign min_x_new = (first || s1_cx_r < min_x_r) ? s1_cx_r : min_x_r;
  assign max_x_new = (first || s1_cx_r > max_x_r) ? s1_cx_r : max_x_r;
  assign min_y_new = (first || s1_cy_r < min_y_r) ? s1_cy_r : min_y_r;
  assign max_y_new = (first || s1_cy_r > max_y_r) ? s1_cy_r : max_y_r;
  // Max never falls below min, so the 17-bit difference is the spread.
  assign spread_x  = (PIX_W+1)'(max_x_new) - (PIX_W+1)'(min_x_new);
  assign spread_y  = (PIX_W+1)'(max_y_new) - (PIX_W+1)'(min_y_new);
  assign too_wide  = (spread_x > (PIX_W+1)'(spread_max_r)) ||
                     (spread_y > (PIX_W+1)'(spread_max_r));

  sca_div_const #(.DIVISOR(WINDOW_SIZE)) u_div_x (
    .num (sum_x_new),
    .quo (avg_x_q)
  );

  sca_div_const #(.DIVISOR(WINDOW_SIZE)) u_div_y (
    .num (sum_y_new),
    .quo (avg_y_q)
  );

  sca_status_t             res_status;
  logic signed [PIX_W-1:0] res_ax;
  logic signed [PIX_W-1:0] res_ay;
  logic signed [POS_W-1:0] res_mx;
  logic signed [POS_W-1:0] res_mz;

  always_comb begin
    last_seq_nxt = last_seq_r;
    count_nxt    = count_r;
    sum_x_nxt    = sum_x_r;
    sum_y_nxt    = sum_y_r;
    min_x_nxt    = min_x_r;
    max_x_nxt    = max_x_r;
    min_y_nxt    = min_y_r;
    max_y_nxt    = max_y_r;
    unstable_nxt = unstable_r;
    done_nxt     = done_r;
    res_status   = ST_IGNORED;
    res_ax       = '0;
    res_ay       = '0;
    res_mx       = '0;
    res_mz       = '0;
    priority if (s1_cmd_r == CMD_START) begin
      last_seq_nxt = s1_seq_r;
      count_nxt    = '0;
      sum_x_nxt    = '0;
      sum_y_nxt    = '0;
      min_x_nxt    = '0;
      max_x_nxt    = '0;
      min_y_nxt    = '0;
      max_y_nxt    = '0;
      unstable_nxt = 1'b0;
      done_nxt     = 1'b0;
    end else if (take) begin
      last_seq_nxt = s1_seq_r;
      if (count_new < CNT_W'(WINDOW_SIZE)) begin
        count_nxt  = count_new;
        sum_x_nxt  = sum_x_new;
        sum_y_nxt  = sum_y_new;
        min_x_nxt  = min_x_new;
        max_x_nxt  = max_x_new;
        min_y_nxt  = min_y_new;
        max_y_nxt  = max_y_new;
        res_status = ST_ACCEPTED;
      end else if (too_wide) begin
        // The window restarts; the sequence number of this sample is kept.
        count_nxt    = '0;
        sum_x_nxt    = '0;
        sum_y_nxt    = '0;
        min_x_nxt    = '0;
        max_x_nxt    = '0;
        min_y_nxt    = '0;
        max_y_nxt    = '0;
        unstable_nxt = 1'b1;
        res_status   = ST_REJECTED;
      end else begin
        count_nxt  = count_new;
        sum_x_nxt  = sum_x_new;
        sum_y_nxt  = sum_y_new;
        min_x_nxt  = min_x_new;
        max_x_nxt  = max_x_new;
        min_y_nxt  = min_y_new;
        max_y_nxt  = max_y_new;
        done_nxt   = 1'b1;
        res_status = ST_POINT;
        res_ax     = avg_x_q;
        res_ay     = avg_y_q;
        res_mx     = s1_mx_r;
        res_mz     = s1_mz_r;
      end
    end else begin
      res_status = ST_IGNORED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seq_r <= '0;
      count_r    <= '0;
      sum_x_r    <= '0;
      sum_y_r    <= '0;
      min_x_r    <= '0;
      max_x_r    <= '0;
      min_y_r    <= '0;
      max_y_r    <= '0;
      unstable_r <= 1'b0;
      done_r     <= 1'b0;
    end else if (adv) begin
      last_seq_r <= last_seq_nxt;
      count_r    <= count_nxt;
      sum_x_r    <= sum_x_nxt;
      sum_y_r    <= sum_y_nxt;
      min_x_r    <= min_x_nxt;
      max_x_r    <= max_x_nxt;
      min_y_r    <= min_y_nxt;
      max_y_r    <= max_y_nxt;
      unstable_r <= unstable_nxt;
      done_r     <= done_nxt;
    end
  end

  // Result register.
  logic                    out_valid_r;
  sca_status_t             out_status_r;
  logic [CNT_W-1:0]        out_count_r;
  logic                    out_unstable_r;
  logic signed [PIX_W-1:0] out_ax_r;
  logic signed [PIX_W-1:0] out_ay_r;
  logic signed [POS_W-1:0] out_mx_r;
  logic signed [POS_W-1:0] out_mz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r   <= res_status;
      out_count_r    <= count_nxt;
      out_unstable_r <= unstable_nxt;
      out_ax_r       <= res_ax;
      out_ay_r       <= res_ay;
      out_mx_r       <= res_mx;
      out_mz_r       <= res_mz;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_mz_r, out_mx_r, out_ay_r, out_ax_r,
                       out_unstable_r, out_count_r};

endmodule
